[rtl/lacc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lacc_pkg
// Shared types and constants for the lamp occupancy and alarm controller.
// ----------------------------------------------------------------------------
package lacc_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 23;

	localparam logic [CFG_INDEX_W-1:0] REG_LAMP_ON_THR  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LAMP_OFF_THR = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_REQ = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VACANCY_DLY  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GAS_THR      = 3'd4;

	// readings are in tenths, thresholds in whole units
	localparam logic [19:0] TENTHS_SCALE = 20'd10;
	localparam logic [31:0] US_PER_MS    = 32'd1000;

	typedef struct packed {
		logic [15:0] lamp_on_threshold;
		logic [15:0] lamp_off_threshold;
		logic        presence_required;
		logic [22:0] vacancy_delay_ms;
		logic [15:0] gas_alarm_threshold;
	} lacc_cfg_t;

	typedef struct packed {
		logic [31:0] now_us;
		logic [19:0] light_tenths;
		logic        person_present;
		logic        flame_seen;
		logic [19:0] gas_tenths;
	} lacc_item_t;

	typedef struct packed {
		logic        lamp_lit;
		logic [31:0] off_deadline;
		logic        fire_alarm_on;
		logic        gas_alarm_on;
		logic        buzzer_on;
		logic        fan_on;
	} lacc_state_t;

	typedef struct packed {
		logic lamp_out;
		logic buzzer_out;
		logic fan_out;
		logic fire_alarm_out;
		logic gas_alarm_out;
		logic fire_raised;
		logic fire_cleared;
		logic gas_raised;
		logic gas_cleared;
	} lacc_result_t;

endpackage
`default_nettype wire

[rtl/lamp_occupancy_and_alarm_controller.sv]
`default_nettype none
// Throughput: one sample per cycle while the result slot is free or being
// drained by out_ready; the single step stage sits between the input register
// and the result register, and the state updates on the same edge.
// Reset (arst_n low, asynchronous): config registers, lamp, deadline, alarms,
// buzzer and fan clear to zero and both pipeline stages empty.
// ----------------------------------------------------------------------------
// lamp_occupancy_and_alarm_controller
// Sensor sample in, lamp/buzzer/fan drives and alarm event pulses out.
// ----------------------------------------------------------------------------
module lamp_occupancy_and_alarm_controller
	import lacc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	input  wire logic [31:0]            now_us,
	input  wire logic [19:0]            light_tenths,
	input  wire logic                   person_present,
	input  wire logic                   flame_seen,
	input  wire logic [19:0]            gas_tenths,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      logic                   lamp_out,
	output      logic                   buzzer_out,
	output      logic                   fan_out,
	output      logic                   fire_alarm_out,
	output      logic                   gas_alarm_out,
	output      logic                   fire_raised,
	output      logic                   fire_cleared,
	output      logic                   gas_raised,
	output      logic                   gas_cleared
);

	lacc_cfg_t    cfg;
	lacc_item_t   item_s1;
	logic         valid_s1;
	lacc_result_t res_s2;
	logic         valid_s2;
	lacc_state_t  state_q;
	lacc_state_t  state_nxt;
	lacc_result_t res_nxt;
	logic         advance;
	logic         in_fire;

	assign cfg_ready = 1'b1;

	lacc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// step the held sample when the result slot is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.now_us         <= now_us;
			item_s1.light_tenths   <= light_tenths;
			item_s1.person_present <= person_present;
			item_s1.flame_seen     <= flame_seen;
			item_s1.gas_tenths     <= gas_tenths;
		end
	end

	lacc_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign lamp_out       = res_s2.lamp_out;
	assign buzzer_out     = res_s2.buzzer_out;
	assign fan_out        = res_s2.fan_out;
	assign fire_alarm_out = res_s2.fire_alarm_out;
	assign gas_alarm_out  = res_s2.gas_alarm_out;
	assign fire_raised    = res_s2.fire_raised;
	assign fire_cleared   = res_s2.fire_cleared;
	assign gas_raised     = res_s2.gas_raised;
	assign gas_cleared    = res_s2.gas_cleared;

`ifndef NO_ASSERTIONS
	a_deadline_needs_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.off_deadline != 32'd0) |-> state_q.lamp_lit)
		else $error("off deadline armed while lamp is off");

	a_gas_raise_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gas_raised) |-> (gas_alarm_out && fan_out && buzzer_out))
		else $error("gas raise without alarm, fan and buzzer on");

	a_fire_pulse_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (fire_raised || fire_cleared)) |-> (fire_alarm_out == fire_raised))
		else $error("fire pulse disagrees with fire alarm state");

	a_result_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("stepped sample did not reach result register");
`endif

endmodule
`default_nettype wire

[rtl/lacc_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lacc_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lacc_cfg
	import lacc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data,
	output lacc_cfg_t                   cfg
);

	lacc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LAMP_ON_THR:  cfg_q.lamp_on_threshold   <= wr_data[15:0];
				REG_LAMP_OFF_THR: cfg_q.lamp_off_threshold  <= wr_data[15:0];
				REG_PRESENCE_REQ: cfg_q.presence_required   <= wr_data[0];
				REG_VACANCY_DLY:  cfg_q.vacancy_delay_ms    <= wr_data[22:0];
				REG_GAS_THR:      cfg_q.gas_alarm_threshold <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[rtl/lacc_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lacc_step
// Combinational update for one sample: deadline, lamp branches, alarms.
// ----------------------------------------------------------------------------
module lacc_step
	import lacc_pkg::*;
(
	input  wire lacc_cfg_t   cfg,
	input  wire lacc_state_t cur,
	input  wire lacc_item_t  item,
	output lacc_state_t      nxt,
	output lacc_result_t     res
);

	logic [19:0] on_thr10;
	logic [19:0] off_thr10;
	logic [19:0] gas_thr10;
	logic [31:0] delay_us;
	logic [31:0] arm_sum;
	logic        arm_wrap;
	logic        dl_passed;
	logic        fire_cond;
	logic        f_raise;
	logic        f_clear;
	logic        g_raise;
	logic        g_clear;

	assign on_thr10  = {4'd0, cfg.lamp_on_threshold} * TENTHS_SCALE;
	assign off_thr10 = {4'd0, cfg.lamp_off_threshold} * TENTHS_SCALE;
	assign gas_thr10 = {4'd0, cfg.gas_alarm_threshold} * TENTHS_SCALE;
	// product wraps at 32 bits like the time base
	assign delay_us  = {9'd0, cfg.vacancy_delay_ms} * US_PER_MS;
	assign arm_sum   = item.now_us + delay_us;
	assign arm_wrap  = (arm_sum != 32'd0) && (item.now_us > arm_sum);
	assign dl_passed = (cur.off_deadline != 32'd0) && (item.now_us > cur.off_deadline);
	assign fire_cond = !item.person_present && item.flame_seen;

	always_comb begin
		nxt     = cur;
		f_raise = 1'b0;
		f_clear = 1'b0;
		g_raise = 1'b0;
		g_clear = 1'b0;

		if (dl_passed) begin
			nxt.lamp_lit     = 1'b0;
			nxt.off_deadline = 32'd0;
		end

		priority if (item.light_tenths < on_thr10) begin
			if (!cfg.presence_required || item.person_present) begin
				if (!nxt.lamp_lit) begin
					nxt.lamp_lit     = 1'b1;
					nxt.off_deadline = 32'd0;
				end
			end else if (nxt.off_deadline == 32'd0 && nxt.lamp_lit) begin
				if (arm_wrap) begin
					nxt.lamp_lit     = 1'b0;
					nxt.off_deadline = 32'd0;
				end else begin
					nxt.off_deadline = arm_sum;
				end
			end
		end else if (item.light_tenths > off_thr10 && nxt.lamp_lit) begin
			nxt.lamp_lit     = 1'b0;
			nxt.off_deadline = 32'd0;
		end else if (cfg.presence_required && nxt.off_deadline == 32'd0 && nxt.lamp_lit) begin
			// between thresholds: arm regardless of presence
			if (arm_wrap) begin
				nxt.lamp_lit     = 1'b0;
				nxt.off_deadline = 32'd0;
			end else begin
				nxt.off_deadline = arm_sum;
			end
		end else begin
			// hold lamp and deadline
		end

		if (fire_cond) begin
			if (!cur.fire_alarm_on) begin
				nxt.fire_alarm_on = 1'b1;
				nxt.buzzer_on     = 1'b1;
				f_raise           = 1'b1;
			end
		end else if (cur.fire_alarm_on) begin
			nxt.fire_alarm_on = 1'b0;
			nxt.buzzer_on     = 1'b0;
			f_clear           = 1'b1;
		end

		// gas handled last, so it has the final word on the shared buzzer
		if (item.gas_tenths > gas_thr10) begin
			if (!cur.gas_alarm_on) begin
				nxt.gas_alarm_on = 1'b1;
				nxt.buzzer_on    = 1'b1;
				nxt.fan_on       = 1'b1;
				g_raise          = 1'b1;
			end
		end else if (cur.gas_alarm_on) begin
			nxt.gas_alarm_on = 1'b0;
			nxt.buzzer_on    = 1'b0;
			nxt.fan_on       = 1'b0;
			g_clear          = 1'b1;
		end
	end

	always_comb begin
		res.lamp_out       = nxt.lamp_lit;
		res.buzzer_out     = nxt.buzzer_on;
		res.fan_out        = nxt.fan_on;
		res.fire_alarm_out = nxt.fire_alarm_on;
		res.gas_alarm_out  = nxt.gas_alarm_on;
		res.fire_raised    = f_raise;
		res.fire_cleared   = f_clear;
		res.gas_raised     = g_raise;
		res.gas_cleared    = g_clear;
	end

endmodule
`default_nettype wire
